// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the band tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBT_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hdl/bbt_pkg.sv -----
// Shared widths, codes and types of the band tracker.
`default_nettype none

package bbt_pkg;

   localparam int PRICE_W            = 24;
   localparam int MEAN_W             = 24;
   localparam int SQ_W               = 2 * PRICE_W;
   localparam int WLEN_W             = 7;
   localparam int DMUL_W             = 12;
   localparam int BAND_W             = 29;
   localparam int FRAC_W             = 8;
   localparam int MAX_WINDOW_DEFAULT = 64;
   localparam int LEN_W_DEFAULT      = $clog2(MAX_WINDOW_DEFAULT + 1);
   localparam int SUM_W_DEFAULT      = PRICE_W + $clog2(MAX_WINDOW_DEFAULT);

   localparam int RSP_FIELDS_W = BAND_W + MEAN_W + BAND_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_MULT      = 2'd1;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
   localparam logic [DMUL_W-1:0] DMUL_RESET = 12'd512;

   localparam logic [BAND_W-1:0] BAND_MAX = 29'h0FFF_FFFF;
   localparam logic [BAND_W-1:0] BAND_MIN = 29'h1000_0000;

   // Status of one bit-serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// ----- hdl/bbt_smul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module bbt_smul import bbt_pkg::*; #(
   parameter int AW = PRICE_W,
   parameter int BW = PRICE_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [AW-1:0]     a,
   input  logic [BW-1:0]     b,
   output unit_status_type   status,
   output logic [AW+BW-1:0]  prod
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0] a_ff, a_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [BW-1:0] lo_ff, lo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [AW:0]   step_sum;

   always_comb begin
      step_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in     = a_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = CW'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // product bits retire into the low half as the multiplier shifts out
         hi_in  = step_sum[AW:1];
         lo_in  = {step_sum[0], lo_ff[BW-1:1]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign prod        = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ----- hdl/bbt_sdiv.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module bbt_sdiv import bbt_pkg::*; #(
   parameter int NW = SUM_W_DEFAULT,
   parameter int DW = LEN_W_DEFAULT,
   parameter int QW = PRICE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NW-1:0]    num,
   input  logic [DW-1:0]    den,
   output unit_status_type  status,
   output logic [QW-1:0]    quo
);

   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, q_ff[QW-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // upper dividend bits are known to stay below the divisor
         rem_in  = DW'(num[NW-1:QW]);
         q_in    = num[QW-1:0];
         den_in  = den;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo         = q_ff;

endmodule

`default_nettype wire

// ----- hdl/bbt_ssqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module bbt_ssqrt import bbt_pkg::*; #(
   parameter int RW = SQ_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RW-1:0]       radicand,
   output unit_status_type     status,
   output logic [RW/2-1:0]     root
);

   localparam int TW = RW / 2;
   localparam int CW = $clog2(TW + 1);

   logic [RW-1:0]   rad_ff, rad_in;
   logic [TW-1:0]   root_ff, root_in;
   logic [TW+1:0]   rem_ff, rem_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [TW+3:0]   rem_ext;
   logic [TW+3:0]   trial;
   logic [TW+3:0]   diff;
   logic            ge;

   always_comb begin
      rem_ext = {rem_ff, rad_ff[RW-1:RW-2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_ext - trial;
      ge      = rem_ext >= trial;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CW'(TW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays at or below twice the partial root
         rad_in  = {rad_ff[RW-3:0], 2'b00};
         rem_in  = ge ? diff[TW+1:0] : rem_ext[TW+1:0];
         root_in = {root_ff[TW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

`default_nettype wire

// ----- hdl/bollinger_band_tracker_unit.sv -----
// Top level of the band tracker: sample ring, running sums and sequencer.
`default_nettype none
`include "assert_macros.svh"

// Takes one price request at a time and returns one result per request:
// lower band, mean and upper band over the last window_length samples, with
// a flag in rsp_tuser that is low (and all bands zero) until the window is
// full. A request whose window is not yet full stops after the first multiply;
// a full window runs all the bit-serial units, which work one bit
// per cycle: the 25-step square-difference multiply, the 48-step divide of
// the sum of squares (the mean divide and mean squaring overlap it), the
// 24-step square root and the 12-step band scaling. A finished result sits
// in the output register, so the next request is taken while it waits. A
// configuration write clears the history and must only happen while idle.
module bollinger_band_tracker_unit import bbt_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PRICE_W-1:0]     req_tdata,   // [23:0] price
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [28:0] lower_band, [52:29] middle_band,
                                               // [81:53] upper_band, [87:82] zero
   output logic                   rsp_tuser,   // [0] valid_res
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LW    = $clog2(MAX_WINDOW);
   localparam int LENW  = $clog2(MAX_WINDOW + 1);
   localparam int SW    = PRICE_W + LW;
   localparam int QSW   = SQ_W + LW;
   localparam int SCL_W = MEAN_W + DMUL_W;
   localparam int BWW   = BAND_W + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_SQMUL = 4'd2;
   localparam logic [3:0] S_DIVST = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_VAR   = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];
   logic [PRICE_W-1:0] old_ff;

   logic [3:0]            state_ff, state_in;
   logic [PRICE_W-1:0]    price_ff, price_in;
   logic                  sub_ff, sub_in;
   logic                  valid_ff, valid_in;
   logic                  neg_ff, neg_in;
   logic [LW-1:0]         ws_ff, ws_in;
   logic [LENW-1:0]       seen_ff, seen_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [QSW-1:0]        sqsum_ff, sqsum_in;
   logic [WLEN_W-1:0]     wlen_ff, wlen_in;
   logic [DMUL_W-1:0]     dmul_ff, dmul_in;
   logic                  res_valid_ff, res_valid_in;
   logic [BAND_W-1:0]     res_lo_ff, res_lo_in;
   logic [MEAN_W-1:0]     res_mid_ff, res_mid_in;
   logic [BAND_W-1:0]     res_hi_ff, res_hi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [LENW-1:0]    len;
   logic               accept;
   logic [LENW:0]      slot_diff;
   logic [LENW:0]      slot_wrap;
   logic [LW-1:0]      old_slot;
   logic [LENW-1:0]    seen_next;
   logic [PRICE_W-1:0] old_eff;
   logic               neg;
   logic [PRICE_W-1:0] mag;
   logic [PRICE_W:0]   pair_sum;
   logic [SQ_W-1:0]    var_val;
   logic [BAND_W-2:0]  scaled;
   logic [BWW-1:0]     lo_wide;
   logic [BWW-1:0]     hi_wide;

   logic                  sqm_start, div_start, msq_start, sqrt_start, scl_start;
   unit_status_type       sqm_st, mdiv_st, sqd_st, msq_st, sqrt_st, scl_st;
   logic [2*PRICE_W:0]    sqm_prod;
   logic [MEAN_W-1:0]     mean;
   logic [SQ_W-1:0]       mean_sq;
   logic [2*MEAN_W-1:0]   msq_prod;
   logic [MEAN_W-1:0]     root;
   logic [SCL_W-1:0]      scl_prod;

   function automatic logic [BAND_W-1:0] sat_band(input logic [BWW-1:0] x);
      logic [BAND_W-1:0] r;
      if (x[BWW-1] != x[BWW-2]) begin
         r = x[BWW-1] ? BAND_MIN : BAND_MAX;
      end else begin
         r = x[BAND_W-1:0];
      end
      return r;
   endfunction

   // window length in use: zero acts as one, clamp at the ring depth
   always_comb begin
      if (wlen_ff == '0) begin
         len = LENW'(1);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         len = LENW'(MAX_WINDOW);
      end else begin
         len = LENW'(wlen_ff);
      end
   end

   assign accept     = req_tvalid && (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      slot_diff = (LENW+1)'(ws_ff) - (LENW+1)'(len);
      slot_wrap = slot_diff[LENW] ? slot_diff + (LENW+1)'(MAX_WINDOW) : slot_diff;
      old_slot  = slot_wrap[LW-1:0];
   end

   // sample ring: the oldest sample is read before the slot is overwritten
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[ws_ff] <= req_tdata;
         old_ff          <= ring_mem[old_slot];
      end
   end

   // p*p - o*o is formed as |p - o| * (p + o)
   always_comb begin
      old_eff  = sub_ff ? old_ff : '0;
      neg      = price_ff < old_eff;
      mag      = neg ? (old_eff - price_ff) : (price_ff - old_eff);
      pair_sum = {1'b0, price_ff} + {1'b0, old_eff};
      var_val  = (mean_sq > msq_prod) ? (mean_sq - msq_prod) : '0;
      scaled   = scl_prod[SCL_W-1:FRAC_W];
      lo_wide  = BWW'(mean) - BWW'(scaled);
      hi_wide  = BWW'(mean) + BWW'(scaled);
   end

   assign sqm_start  = (state_ff == S_READ);
   assign div_start  = (state_ff == S_DIVST);
   assign msq_start  = mdiv_st.done;
   assign sqrt_start = (state_ff == S_VAR);
   assign scl_start  = sqrt_st.done;

   always_comb begin
      state_in     = state_ff;
      price_in     = price_ff;
      sub_in       = sub_ff;
      valid_in     = valid_ff;
      neg_in       = neg_ff;
      ws_in        = ws_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      wlen_in      = wlen_ff;
      dmul_in      = dmul_ff;
      res_valid_in = res_valid_ff;
      res_lo_in    = res_lo_ff;
      res_mid_in   = res_mid_ff;
      res_hi_in    = res_hi_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      seen_next    = (seen_ff >= len) ? seen_ff : seen_ff + LENW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               price_in = req_tdata;
               sub_in   = seen_ff >= len;
               seen_in  = seen_next;
               valid_in = seen_next >= len;
               ws_in    = (ws_ff == LW'(MAX_WINDOW - 1)) ? '0 : ws_ff + LW'(1);
               state_in = S_READ;
            end
         end
         S_READ: begin
            sum_in   = sum_ff + SW'(price_ff) - SW'(old_eff);
            neg_in   = neg;
            state_in = S_SQMUL;
         end
         S_SQMUL: begin
            if (sqm_st.done) begin
               sqsum_in = neg_ff ? (sqsum_ff - QSW'(sqm_prod))
                                 : (sqsum_ff + QSW'(sqm_prod));
               if (valid_ff) begin
                  state_in = S_DIVST;
               end else begin
                  res_valid_in = 1'b0;
                  res_lo_in    = '0;
                  res_mid_in   = '0;
                  res_hi_in    = '0;
                  state_in     = S_DONE;
               end
            end
         end
         S_DIVST: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            // mean squaring starts when the mean is out and ends after the
            // longer divide, so its done marks both
            if (msq_st.done) begin
               state_in = S_VAR;
            end
         end
         S_VAR: begin
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sqrt_st.done) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (scl_st.done) begin
               res_valid_in = 1'b1;
               res_lo_in    = sat_band(lo_wide);
               res_mid_in   = mean;
               res_hi_in    = sat_band(hi_wide);
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_valid_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, res_hi_ff, res_mid_ff, res_lo_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wen) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: wlen_in = csr_wdata[WLEN_W-1:0];
            CSR_DEV_MULT:      dmul_in = csr_wdata[DMUL_W-1:0];
            default: ;
         endcase
         ws_in    = '0;
         seen_in  = '0;
         sum_in   = '0;
         sqsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ws_ff        <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         wlen_ff      <= WLEN_RESET;
         dmul_ff      <= DMUL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         wlen_ff      <= wlen_in;
         dmul_ff      <= dmul_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff     <= price_in;
      sub_ff       <= sub_in;
      valid_ff     <= valid_in;
      neg_ff       <= neg_in;
      res_valid_ff <= res_valid_in;
      res_lo_ff    <= res_lo_in;
      res_mid_ff   <= res_mid_in;
      res_hi_ff    <= res_hi_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   bbt_smul #(.AW(PRICE_W), .BW(PRICE_W + 1)) u_sqm (
      .clock  (clock),
      .reset  (reset),
      .start  (sqm_start),
      .a      (mag),
      .b      (pair_sum),
      .status (sqm_st),
      .prod   (sqm_prod)
   );

   bbt_sdiv #(.NW(SW), .DW(LENW), .QW(MEAN_W)) u_mdiv (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (sum_ff),
      .den    (len),
      .status (mdiv_st),
      .quo    (mean)
   );

   bbt_sdiv #(.NW(QSW), .DW(LENW), .QW(SQ_W)) u_sqd (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (sqsum_ff),
      .den    (len),
      .status (sqd_st),
      .quo    (mean_sq)
   );

   bbt_smul #(.AW(MEAN_W), .BW(MEAN_W)) u_msq (
      .clock  (clock),
      .reset  (reset),
      .start  (msq_start),
      .a      (mean),
      .b      (mean),
      .status (msq_st),
      .prod   (msq_prod)
   );

   bbt_ssqrt #(.RW(SQ_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (var_val),
      .status   (sqrt_st),
      .root     (root)
   );

   bbt_smul #(.AW(MEAN_W), .BW(DMUL_W)) u_scl (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .a      (root),
      .b      (dmul_ff),
      .status (scl_st),
      .prod   (scl_prod)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `BBT_ASSERT_IMP(a_div_before_square, clock, reset, msq_st.done, !sqd_st.busy, "mean square ready before sum-of-squares divide")
   `BBT_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_tvalid && req_tready, state_ff == S_READ, "accepted request did not start work")
   `BBT_ASSERT_IMP(a_fill_zero_bands, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "bands not zero while window fills")
   `BBT_ASSERT_IMP(a_seen_bounded, clock, reset, state_ff == S_IDLE, seen_ff <= len, "sample count above window length")

endmodule

`default_nettype wire
